[src/tile_queue_match_remove_unit_assert.svh]
// ----------------------------------------------------------------------------
// Tile queue match-remove unit: assertion macros
// Concurrent checks on clk, disabled while rst_n is low. Defining
// NO_ASSERTIONS turns every check into nothing.
// ----------------------------------------------------------------------------
`ifndef TILE_QUEUE_MATCH_REMOVE_UNIT_ASSERT_SVH
`define TILE_QUEUE_MATCH_REMOVE_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Consequence must hold in the same cycle as the antecedent.
`define TQMR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tqmr: same-cycle check failed");

// Consequence must hold in the cycle after the antecedent.
`define TQMR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tqmr: next-cycle check failed");

`else

`define TQMR_ASSERT_NOW(label, ante, cons)
`define TQMR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[src/tqmr_pkg.sv]
// ----------------------------------------------------------------------------
// Tile queue match-remove package
// Sizes, beat types, operation, status and state codes and the cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package tqmr_pkg;

  localparam int DEPTH = 128;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef logic [11:0] entry_t;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_TAKE   = 2'd1,
    OP_MATCH  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] colour;
    logic [3:0] shape;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] taken_colour;
    logic [3:0] taken_shape;
    logic [7:0] count;
  } out_item_t;

  // Shared control for every cell of the chain.
  typedef struct packed {
    logic             shift;
    logic             load;
    logic [IDX_W-1:0] load_idx;
    entry_t           load_data;
  } cell_ctl_t;

endpackage

`default_nettype wire

[src/tile_queue_match_remove_unit.sv]
// Append, take head and clear give their result beat in the cycle after the
// accepting edge; remove-first-match over n held items gives it once the
// rotation through all n has ended (in the cycle after, when the store is empty).
// Throughput: one append, take or clear per cycle while busy is low; a match holds busy
// high for its rotation, one rotation step of the cell chain per cycle. Reset clears
// state, count and out_valid only; the receiver cannot stall, each beat lasts one cycle.
// ----------------------------------------------------------------------------
// Tile queue match-remove unit
// Ordered store of colour/shape items kept in a chain of cells, head at
// cell zero, with append, take head, remove first match and clear.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tile_queue_match_remove_unit_assert.svh"

module tile_queue_match_remove_unit (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire tqmr_pkg::in_item_t   in_item,
  output logic                      out_valid,
  output tqmr_pkg::out_item_t       out_item
);
  import tqmr_pkg::*;

  // Control and result registers.
  state_t           state_r,     state_nxt;
  logic [CNT_W-1:0] count_r,     count_nxt;
  logic [CNT_W-1:0] remain_r,    remain_nxt;
  entry_t           key_r,       key_nxt;
  logic             found_r,     found_nxt;
  entry_t           taken_r,     taken_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r,       out_nxt;

  cell_ctl_t cell_ctl;
  entry_t    cell_data [DEPTH];
  entry_t    head;
  entry_t    in_key;
  logic      drop;

  // The chain of cells. Each cell hands its entry to the one nearer the
  // head on a shift; the last cell has no neighbour behind it and simply
  // sees the load data, which is never used while it is beyond the tail.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == DEPTH - 1) begin : g_last
      tqmr_cell u_cell (
        .clk      (clk),
        .cell_idx (IDX_W'(g)),
        .ctl      (cell_ctl),
        .nbr_data (cell_ctl.load_data),
        .data     (cell_data[g])
      );
    end else begin : g_mid
      tqmr_cell u_cell (
        .clk      (clk),
        .cell_idx (IDX_W'(g)),
        .ctl      (cell_ctl),
        .nbr_data (cell_data[g+1]),
        .data     (cell_data[g])
      );
    end
  end

  assign head   = cell_data[0];
  assign in_key = {in_item.colour, in_item.shape};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    remain_r <= remain_nxt;
    key_r    <= key_nxt;
    found_r  <= found_nxt;
    taken_r  <= taken_nxt;
    out_r    <= out_nxt;
  end

  // Next state, cell control and result beat.
  // A match rotates the whole queue once through the chain: each cycle the
  // head item leaves cell zero, everything moves one place towards the head,
  // and the old head is written back at the tail. The first head that
  // matches the key is not written back, which removes it while keeping the
  // order of the rest intact once the full rotation has finished.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    remain_nxt    = remain_r;
    key_nxt       = key_r;
    found_nxt     = found_r;
    taken_nxt     = taken_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    cell_ctl      = '0;
    drop          = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          out_nxt.status       = STATUS_OK;
          out_nxt.taken_colour = '0;
          out_nxt.taken_shape  = '0;
          case (in_item.op)
            OP_APPEND: begin
              out_valid_nxt = 1'b1;
              if (count_r == CNT_W'(DEPTH)) begin
                out_nxt.status = STATUS_FULL;
              end else begin
                cell_ctl.load      = 1'b1;
                cell_ctl.load_idx  = IDX_W'(count_r);
                cell_ctl.load_data = in_key;
                count_nxt          = count_r + CNT_W'(1);
              end
            end
            OP_TAKE: begin
              out_valid_nxt = 1'b1;
              if (count_r == '0) begin
                out_nxt.status = STATUS_EMPTY;
              end else begin
                cell_ctl.shift       = 1'b1;
                out_nxt.taken_colour = head[11:4];
                out_nxt.taken_shape  = head[3:0];
                count_nxt            = count_r - CNT_W'(1);
              end
            end
            OP_MATCH: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = STATUS_EMPTY;
              end else begin
                key_nxt    = in_key;
                remain_nxt = count_r;
                found_nxt  = 1'b0;
                taken_nxt  = '0;
                state_nxt  = S_SCAN;
              end
            end
            OP_CLEAR: begin
              out_valid_nxt = 1'b1;
              count_nxt     = '0;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
          out_nxt.count = 8'(count_nxt);
        end
      end

      S_SCAN: begin
        cell_ctl.shift = 1'b1;
        drop           = !found_r && (head == key_r);
        if (drop) begin
          found_nxt = 1'b1;
          taken_nxt = head;
          count_nxt = count_r - CNT_W'(1);
        end else begin
          cell_ctl.load      = 1'b1;
          cell_ctl.load_idx  = IDX_W'(count_r - CNT_W'(1));
          cell_ctl.load_data = head;
        end
        remain_nxt = remain_r - CNT_W'(1);
        if (remain_r == CNT_W'(1)) begin
          out_valid_nxt        = 1'b1;
          out_nxt.status       = found_nxt ? STATUS_OK : STATUS_EMPTY;
          out_nxt.taken_colour = taken_nxt[11:4];
          out_nxt.taken_shape  = taken_nxt[3:0];
          out_nxt.count        = 8'(count_nxt);
          state_nxt            = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r == S_SCAN);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // The store never holds more items than it has cells.
  `TQMR_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH))

  // Every operation other than a match on a non-empty store answers at once.
  `TQMR_ASSERT_NEXT(a_quick_answer, start && !busy && (in_item.op != OP_MATCH), out_valid)

  // No result beat goes out while a rotation is still under way.
  `TQMR_ASSERT_NOW(a_quiet_scan, state_r == S_SCAN, !out_valid)

  // Dropping the matching head removes exactly one item.
  `TQMR_ASSERT_NEXT(a_drop_count, drop, count_r == $past(count_r) - CNT_W'(1))

endmodule

`default_nettype wire

[src/tqmr_cell.sv]
// ----------------------------------------------------------------------------
// Tile queue cell
// Holds one entry. It takes its neighbour's entry on a shift, or the load
// data when its own index is the one addressed.
// ----------------------------------------------------------------------------
`default_nettype none

module tqmr_cell (
  input  wire logic                         clk,
  input  wire logic [tqmr_pkg::IDX_W-1:0]   cell_idx,
  input  wire tqmr_pkg::cell_ctl_t          ctl,
  input  wire tqmr_pkg::entry_t             nbr_data,
  output tqmr_pkg::entry_t                  data
);
  import tqmr_pkg::*;

  entry_t data_r;
  entry_t data_nxt;
  logic   hit;

  always_comb begin
    hit      = ctl.load && (ctl.load_idx == cell_idx);
    data_nxt = data_r;
    if (hit) begin
      data_nxt = ctl.load_data;
    end else if (ctl.shift) begin
      data_nxt = nbr_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

`default_nettype wire

[test/tb_tile_queue_match_remove_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile queue match-remove unit testbench
// Drives append, take head, remove first match and clear commands through
// the start/busy handshake and checks every result beat against a shadow
// copy of the store. A short table of directed commands comes first, then
// random episodes that build up, fill and drain the store, under three
// sender idling rates.
// ----------------------------------------------------------------------------

module tb_tile_queue_match_remove_unit;
  import tqmr_pkg::*;

  // The longest scan is a match over a full store.
  localparam int DRAIN_CYCLES = DEPTH + 4;
  localparam int ITEMS_PER_PHASE = 330;
  localparam int MAX_GAP = 20;

  typedef enum int {
    MODE_MIX,
    MODE_FILL,
    MODE_DRAIN
  } mode_t;

  // One row of the directed table. A row may repeat its command; on each
  // repeat the colour and shape are stepped on by the repeat index.
  typedef struct {
    op_t        op;
    logic [7:0] colour;
    logic [3:0] shape;
    int         reps;
    bit         typed;
    out_item_t  typed_res;
  } plan_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  // Shadow copy of the store, head first, and the beats still owed by the
  // block, oldest first.
  entry_t    shadow_tiles[$];
  out_item_t awaited_beats[$];
  plan_row_t plan[$];

  int mismatch_count = 0;
  int idle_pct = 0;

  tile_queue_match_remove_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one command to the shadow store and returns the beat that the
  // block should give for it.
  function automatic out_item_t predict_outcome(in_item_t cmd);
    out_item_t res;
    entry_t    key;
    entry_t    hit_tile;
    int        hit;
    res = '0;
    key = {cmd.colour, cmd.shape};
    case (cmd.op)
      OP_APPEND: begin
        if (shadow_tiles.size() >= DEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          shadow_tiles.push_back(key);
        end
      end
      OP_TAKE: begin
        if (shadow_tiles.size() == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          hit_tile = shadow_tiles.pop_front();
          {res.taken_colour, res.taken_shape} = hit_tile;
        end
      end
      OP_MATCH: begin
        // Only the first matching tile, counted from the head, goes; the
        // ones behind it close up, which a queue delete gives for free.
        hit = -1;
        for (int i = 0; i < shadow_tiles.size(); i++) begin
          if (hit < 0 && shadow_tiles[i] == key) hit = i;
        end
        if (hit < 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          {res.taken_colour, res.taken_shape} = shadow_tiles[hit];
          shadow_tiles.delete(hit);
        end
      end
      default: begin
        shadow_tiles.delete();
      end
    endcase
    res.count = 8'(shadow_tiles.size());
    return res;
  endfunction

  // Builds a random command for the given kind of episode. Matches mostly
  // aim at tiles that are held, so that the scan finds something, with the
  // odd single-bit near miss; appends sometimes copy a held tile so that
  // duplicates exist and the first-match rule is exercised.
  function automatic in_item_t pick_command(mode_t mode);
    in_item_t cmd;
    entry_t   key;
    int       r;
    cmd.colour = 8'($urandom);
    cmd.shape  = 4'($urandom);
    r = $urandom_range(99);
    case (mode)
      MODE_FILL:  cmd.op = (r < 90) ? OP_APPEND : OP_MATCH;
      MODE_DRAIN: cmd.op = (r < 50) ? OP_TAKE : (r < 95) ? OP_MATCH : OP_APPEND;
      default:    cmd.op = (r < 45) ? OP_APPEND : (r < 65) ? OP_TAKE :
                           (r < 98) ? OP_MATCH : OP_CLEAR;
    endcase
    if (shadow_tiles.size() != 0) begin
      key = shadow_tiles[$urandom_range(shadow_tiles.size() - 1)];
      if (cmd.op == OP_MATCH && $urandom_range(99) < 75) begin
        if ($urandom_range(9) == 0) key ^= entry_t'(1 << $urandom_range(11));
        {cmd.colour, cmd.shape} = key;
      end else if (cmd.op == OP_APPEND && $urandom_range(99) < 20) begin
        {cmd.colour, cmd.shape} = key;
      end
    end
    return cmd;
  endfunction

  // Presents one command and waits for the edge that accepts it. The task
  // is entered in the time step of a rising edge, and start is assigned at
  // most once in any step, so a back-to-back beat keeps start high.
  task automatic issue_command(in_item_t cmd, bit typed, out_item_t typed_res);
    out_item_t res;
    int        gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= cmd;
    // busy is read before the block updates it at this edge.
    do @(posedge clk); while (busy !== 1'b0);
    res = predict_outcome(cmd);
    awaited_beats.push_back(typed ? typed_res : res);
  endtask

  task automatic add_row(op_t op, logic [7:0] colour, logic [3:0] shape, int reps,
                         bit typed, out_item_t typed_res);
    plan_row_t row;
    row.op        = op;
    row.colour    = colour;
    row.shape     = shape;
    row.reps      = reps;
    row.typed     = typed;
    row.typed_res = typed_res;
    plan.push_back(row);
  endtask

  task automatic report_mismatch(string what, out_item_t want, out_item_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s: expected status %0d colour %02h shape %01h count %0d,",
               $realtime, what, want.status, want.taken_colour, want.taken_shape,
               want.count);
      $display("%0t:   got status %0d colour %02h shape %01h count %0d",
               $realtime, got.status, got.taken_colour, got.taken_shape, got.count);
    end
  endtask

  // Result side. Beats cannot be held off, so every strobe seen at an edge
  // is a delivered beat and is matched against the oldest expectation.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid !== 1'b0) begin
      if (awaited_beats.size() == 0) begin
        report_mismatch("result beat with nothing outstanding", '0, out_item);
      end else begin
        want = awaited_beats.pop_front();
        if (out_item.status !== want.status ||
            out_item.taken_colour !== want.taken_colour ||
            out_item.taken_shape !== want.taken_shape ||
            out_item.count !== want.count) begin
          report_mismatch("result beat differs", want, out_item);
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    in_item_t cmd;
    mode_t    mode;
    int       phase_items;
    int       episode_len;
    int       r;
    int       guard;

    // Directed table. Rows with a typed result are ones whose outcome is
    // plain from the command history; the rest rely on the shadow store.
    // Taking from and matching in an empty store both report empty.
    add_row(OP_TAKE,   8'h00, 4'h0, 1, 1'b1, {STATUS_EMPTY, 8'h00, 4'h0, 8'd0});
    add_row(OP_MATCH,  8'h5A, 4'h3, 1, 1'b1, {STATUS_EMPTY, 8'h00, 4'h0, 8'd0});
    add_row(OP_CLEAR,  8'hFF, 4'hF, 1, 1'b1, {STATUS_OK,    8'h00, 4'h0, 8'd0});
    // Field extremes, then a duplicate of the all-ones tile.
    add_row(OP_APPEND, 8'h00, 4'h0, 1, 1'b1, {STATUS_OK,    8'h00, 4'h0, 8'd1});
    add_row(OP_APPEND, 8'hFF, 4'hF, 1, 1'b1, {STATUS_OK,    8'h00, 4'h0, 8'd2});
    add_row(OP_APPEND, 8'hA5, 4'h6, 1, 1'b1, {STATUS_OK,    8'h00, 4'h0, 8'd3});
    add_row(OP_APPEND, 8'hFF, 4'hF, 1, 1'b1, {STATUS_OK,    8'h00, 4'h0, 8'd4});
    // The first of the two all-ones tiles goes; near misses in either field
    // find nothing.
    add_row(OP_MATCH,  8'hFF, 4'hF, 1, 1'b1, {STATUS_OK,    8'hFF, 4'hF, 8'd3});
    add_row(OP_MATCH,  8'hFF, 4'hE, 1, 1'b1, {STATUS_EMPTY, 8'h00, 4'h0, 8'd3});
    add_row(OP_MATCH,  8'hFE, 4'hF, 1, 1'b1, {STATUS_EMPTY, 8'h00, 4'h0, 8'd3});
    // Order is kept after the removal.
    add_row(OP_TAKE,   8'h00, 4'h0, 1, 1'b1, {STATUS_OK,    8'h00, 4'h0, 8'd2});
    add_row(OP_TAKE,   8'h00, 4'h0, 1, 1'b1, {STATUS_OK,    8'hA5, 4'h6, 8'd1});
    add_row(OP_TAKE,   8'h00, 4'h0, 1, 1'b1, {STATUS_OK,    8'hFF, 4'hF, 8'd0});
    add_row(OP_TAKE,   8'h00, 4'h0, 1, 1'b1, {STATUS_EMPTY, 8'h00, 4'h0, 8'd0});
    // Fill to the brim and push past it; the refused appends leave the
    // store as it was.
    add_row(OP_APPEND, 8'h12, 4'h3, 1, 1'b0, '0);
    add_row(OP_APPEND, 8'h40, 4'h0, DEPTH + 1, 1'b0, '0);
    add_row(OP_APPEND, 8'h77, 4'h5, 1, 1'b1, {STATUS_FULL, 8'h00, 4'h0, 8'(DEPTH)});
    // Longest scan (the tail tile) on a full store, then the head tile.
    add_row(OP_MATCH,  8'hBE, 4'hE, 1, 1'b0, '0);
    add_row(OP_MATCH,  8'h12, 4'h3, 1, 1'b0, '0);
    add_row(OP_TAKE,   8'h00, 4'h0, 1, 1'b0, '0);
    add_row(OP_CLEAR,  8'h00, 4'h0, 1, 1'b1, {STATUS_OK,    8'h00, 4'h0, 8'd0});
    add_row(OP_MATCH,  8'h00, 4'h0, 1, 1'b1, {STATUS_EMPTY, 8'h00, 4'h0, 8'd0});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    idle_pct = 8;
    foreach (plan[i]) begin
      for (int k = 0; k < plan[i].reps; k++) begin
        cmd.op     = plan[i].op;
        cmd.colour = plan[i].colour + 8'(k);
        cmd.shape  = plan[i].shape + 4'(k);
        issue_command(cmd, plan[i].typed, plan[i].typed_res);
      end
    end

    // Random part: a light idling rate, then a heavy one, then none. Each
    // phase is made of episodes that mix, fill (often to the point of
    // refusal) or drain the store.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 8 : (phase == 1) ? 58 : 0;
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        r = $urandom_range(99);
        if (r < 60) begin
          mode = MODE_MIX;
          episode_len = $urandom_range(60, 20);
        end else if (r < 85) begin
          mode = MODE_FILL;
          episode_len = $urandom_range(160, 60);
        end else begin
          mode = MODE_DRAIN;
          episode_len = $urandom_range(80, 20);
        end
        repeat (episode_len) begin
          issue_command(pick_command(mode), 1'b0, '0);
          phase_items++;
        end
      end
    end
    start <= 1'b0;

    // Wait for the last beats, sampling between edges, then allow for a
    // scan still in flight.
    guard = 0;
    while (awaited_beats.size() != 0 && guard < 4 * DRAIN_CYCLES) begin
      @(negedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_beats.size() != 0) begin
      $display("%0t: %0d result beats never arrived", $realtime, awaited_beats.size());
      mismatch_count += awaited_beats.size();
    end

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin : watchdog
    #(64'd10_000_000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
